// ----- sv/lslg_pkg.sv -----
// Shared types, register indexes and threshold tables for the load-shedding
// level governor. No dependencies; used by every module of the block.
`default_nettype none

package lslg_pkg;

    // Request kinds
    localparam logic REQ_FRAME = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_EVAL_INTERVAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_TUNE     = 1'd1;

    // Reset values
    localparam logic [15:0] EVAL_INTERVAL_RST = 16'd2000;
    localparam logic        AUTO_TUNE_RST     = 1'b1;
    localparam logic [23:0] AVG_RST           = 24'd20480;   // 80.0 ms in Q16.8

    // Smoothing factor 0.15 in Q0.16
    localparam logic [13:0] ALPHA_Q16 = 14'd9830;
    localparam logic [23:0] AVG_MAX   = 24'hFF_FFFF;

    localparam logic [1:0] LEVEL_MIN = 2'd0;
    localparam logic [1:0] LEVEL_MAX = 2'd3;

    typedef struct packed {
        logic        req_type;
        logic [15:0] frame_ms;
        logic [31:0] now_ms;
        logic [31:0] free_heap;
        logic [31:0] max_alloc;
    } lslg_req_t;

    typedef struct packed {
        logic [1:0]  load_level;
        logic        effects_off;
        logic        sweep_simple;
        logic        detail_reduced;
        logic [23:0] avg_frame_ms;
        logic        evaluated;
    } lslg_rsp_t;

    // Escalate thresholds, indexed by the current level (0..2)
    function automatic logic [23:0] esc_frame(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    esc_frame = 24'd51200;
            2'd1:    esc_frame = 24'd89600;
            2'd2:    esc_frame = 24'd153600;
            default: esc_frame = AVG_MAX;
        endcase
    endfunction

    function automatic logic [31:0] esc_heap(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    esc_heap = 32'd40000;
            2'd1:    esc_heap = 32'd25000;
            2'd2:    esc_heap = 32'd15000;
            default: esc_heap = 32'd0;
        endcase
    endfunction

    function automatic logic [31:0] esc_alloc(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    esc_alloc = 32'd20000;
            2'd1:    esc_alloc = 32'd12000;
            2'd2:    esc_alloc = 32'd8000;
            default: esc_alloc = 32'd0;
        endcase
    endfunction

    // Recover thresholds, indexed by the level below the current one (0..2)
    function automatic logic [23:0] rec_frame(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    rec_frame = 24'd35840;
            2'd1:    rec_frame = 24'd64000;
            2'd2:    rec_frame = 24'd115200;
            default: rec_frame = 24'd0;
        endcase
    endfunction

    function automatic logic [31:0] rec_heap(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    rec_heap = 32'd55000;
            2'd1:    rec_heap = 32'd35000;
            2'd2:    rec_heap = 32'd22000;
            default: rec_heap = 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] rec_alloc(input logic [1:0] lvl);
        unique case (lvl)
            2'd0:    rec_alloc = 32'd30000;
            2'd1:    rec_alloc = 32'd18000;
            2'd2:    rec_alloc = 32'd11000;
            default: rec_alloc = 32'hFFFF_FFFF;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- sv/lslg_ema.sv -----
// Smoothed frame-time register and its exponential-average update.
// Depends on lslg_pkg.
`default_nettype none

module lslg_ema (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [15:0] frame_ms,
    output logic      [23:0] avg_next
);

    logic        [23:0] avg_reg;
    logic signed [24:0] diff;
    logic signed [39:0] prod;
    logic signed [23:0] delta;
    logic signed [25:0] sum;
    logic        [23:0] avg_upd;

    // diff = frame in Q16.8 minus average; delta = floor(diff * alpha)
    always_comb
    begin
        diff  = $signed({1'b0, frame_ms, 8'd0}) - $signed({1'b0, avg_reg});
        prod  = 40'(diff) * 40'($signed({1'b0, lslg_pkg::ALPHA_Q16}));
        delta = prod[39:16];
        sum   = $signed({2'b00, avg_reg}) + 26'(delta);
        if (sum[25])
            avg_upd = 24'd0;
        else if (sum[24])
            avg_upd = lslg_pkg::AVG_MAX;
        else
            avg_upd = sum[23:0];
        avg_next = step ? avg_upd : avg_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            avg_reg <= lslg_pkg::AVG_RST;
        else
            avg_reg <= avg_next;
    end

endmodule

`default_nettype wire

// ----- sv/lslg_eval.sv -----
// Level register, last-evaluation time stamp and the one-step level decision.
// Depends on lslg_pkg.
`default_nettype none

module lslg_eval (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [15:0] eval_interval,
    input  wire logic        auto_tune,
    input  wire logic [23:0] avg_q,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] free_heap,
    input  wire logic [31:0] max_alloc,
    output logic      [1:0]  level_next,
    output logic             evaluated
);

    logic [1:0]  level_reg;
    logic [31:0] last_eval_reg;
    logic [31:0] last_eval_next;
    logic [31:0] elapsed;
    logic [1:0]  below;
    logic        too_early;
    logic        escalate;
    logic        recover;

    // Threshold compares against the current level
    always_comb
    begin
        elapsed   = now_ms - last_eval_reg;
        too_early = elapsed < {16'd0, eval_interval};
        below     = level_reg - 2'd1;
        escalate  = (level_reg != lslg_pkg::LEVEL_MAX) &&
                    ((avg_q > lslg_pkg::esc_frame(level_reg)) ||
                     (free_heap < lslg_pkg::esc_heap(level_reg)) ||
                     (max_alloc < lslg_pkg::esc_alloc(level_reg)));
        recover   = (level_reg != lslg_pkg::LEVEL_MIN) &&
                    (avg_q < lslg_pkg::rec_frame(below)) &&
                    (free_heap > lslg_pkg::rec_heap(below)) &&
                    (max_alloc > lslg_pkg::rec_alloc(below));
    end

    // Level update; escalation wins over recovery
    always_comb
    begin
        level_next     = level_reg;
        last_eval_next = last_eval_reg;
        evaluated      = 1'b0;
        if (step)
        begin
            if (!auto_tune)
                level_next = lslg_pkg::LEVEL_MIN;
            else if (!too_early)
            begin
                evaluated      = 1'b1;
                last_eval_next = now_ms;
                if (escalate)
                    level_next = level_reg + 2'd1;
                else if (recover)
                    level_next = below;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= lslg_pkg::LEVEL_MIN;
            last_eval_reg <= 32'd0;
        end
        else
        begin
            level_reg     <= level_next;
            last_eval_reg <= last_eval_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/load_shedding_level_governor_top.sv -----
// Load-shedding level governor, top level: item register, config registers,
// result register. Depends on lslg_pkg, lslg_ema and lslg_eval.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one item: a frame-time
//   record (req_type 0) or an evaluation request (req_type 1).
//   rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per
//   item: level, its three flags, the smoothed frame time and whether the
//   item performed an evaluation.
//   A result is registered: the item sits in the item register, then the
//   state update loads the result register. Throughput: one item per
//   cycle while rsp_ready stays high; the average and level update are
//   one constant multiply, an add and a few compares.
//   When rsp_ready is low the result register holds, the item register
//   still takes one more item, then req_ready drops until the result leaves.
//   Reset: average 80.0 ms, level 0, last evaluation time 0, interval 2000 ms,
//   auto tuning on. cfg_we writes the evaluation interval (index 0) or
//   auto_tune_enable (index 1); write only while idle.
`default_nettype none

module load_shedding_level_governor_top (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_ready,
    input  wire lslg_pkg::lslg_req_t                     req,
    output logic                                         rsp_valid,
    input  wire logic                                    rsp_ready,
    output lslg_pkg::lslg_rsp_t                          rsp,
    input  wire logic                                    cfg_we,
    input  wire logic [lslg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [lslg_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic                stage_valid_reg;
    logic                stage_valid_next;
    lslg_pkg::lslg_req_t stage_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    lslg_pkg::lslg_rsp_t rsp_reg;
    lslg_pkg::lslg_rsp_t rsp_next;
    logic [15:0]         eval_interval_reg;
    logic                auto_tune_reg;
    logic                advance;
    logic                frame_step;
    logic                eval_step;
    logic [23:0]         avg_next;
    logic [1:0]          level_next;
    logic                evaluated;
    logic [1:0]          u_eval_level_cur;
    logic [1:0]          level_shadow_reg;

    // Handshake: the item stage moves whenever the result register is free
    always_comb
    begin
        advance          = stage_valid_reg && (!rsp_valid_reg || rsp_ready);
        req_ready        = !stage_valid_reg || advance;
        frame_step       = advance && (stage_reg.req_type == lslg_pkg::REQ_FRAME);
        eval_step        = advance && (stage_reg.req_type == lslg_pkg::REQ_EVAL);
        stage_valid_next = (req_valid && req_ready) ? 1'b1 :
                           (advance ? 1'b0 : stage_valid_reg);
        rsp_valid_next   = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_interval_reg <= lslg_pkg::EVAL_INTERVAL_RST;
            auto_tune_reg     <= lslg_pkg::AUTO_TUNE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lslg_pkg::CFG_EVAL_INTERVAL: eval_interval_reg <= cfg_data;
                lslg_pkg::CFG_AUTO_TUNE:     auto_tune_reg     <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // Item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            stage_reg <= req;
    end

    lslg_ema u_ema (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (frame_step),
        .frame_ms (stage_reg.frame_ms),
        .avg_next (avg_next)
    );

    lslg_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (eval_step),
        .eval_interval (eval_interval_reg),
        .auto_tune     (auto_tune_reg),
        .avg_q         (avg_next),
        .now_ms        (stage_reg.now_ms),
        .free_heap     (stage_reg.free_heap),
        .max_alloc     (stage_reg.max_alloc),
        .level_next    (level_next),
        .evaluated     (evaluated)
    );

    // Result assembly
    always_comb
    begin
        rsp_next.load_level     = level_next;
        rsp_next.effects_off    = (level_next != 2'd0);
        rsp_next.sweep_simple   = level_next[1];
        rsp_next.detail_reduced = (level_next == lslg_pkg::LEVEL_MAX);
        rsp_next.avg_frame_ms   = avg_next;
        rsp_next.evaluated      = evaluated;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Shadow of the current level, taken from the previous result path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_shadow_reg <= lslg_pkg::LEVEL_MIN;
        else
            level_shadow_reg <= level_next;
    end

    assign u_eval_level_cur = level_shadow_reg;

    // The stage never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten while stalled");

    // Flags always agree with the reported level
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.effects_off == (rsp.load_level != 2'd0)) &&
                       (rsp.sweep_simple == rsp.load_level[1]) &&
                       (rsp.detail_reduced == (rsp.load_level == 2'd3))))
        else $error("level flags inconsistent with load_level");

    // With auto tuning on, the level moves by at most one step per item
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_step && auto_tune_reg) |->
            (({1'b0, level_next} == {1'b0, u_eval_level_cur} + 3'd1) ||
             ({1'b0, level_next} + 3'd1 == {1'b0, u_eval_level_cur}) ||
             (level_next == u_eval_level_cur)))
        else $error("level moved by more than one step");

endmodule

`default_nettype wire

// ----- verif/lslg_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the load-shedding level governor: mirrors the average,
// level and evaluation time from accepted items and register writes.
// Depends on lslg_pkg; sits beside the block and only watches its ports.

module lslg_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic                                 req_ready,
    input  lslg_pkg::lslg_req_t                  req,
    input  logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    input  lslg_pkg::lslg_rsp_t                  rsp,
    input  logic                                 cfg_we,
    input  logic [lslg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lslg_pkg::CFG_DATA_W-1:0]      cfg_data,
    output int unsigned                          mismatches,
    output int unsigned                          outstanding,
    output int unsigned                          results_seen,
    output int unsigned                          evaluations,
    output logic [3:0]                           levels_hit
);

    // Thresholds per level, entry 0 in the low word
    localparam logic [2:0][31:0] RISE_AVG   = {32'd153600, 32'd89600, 32'd51200};
    localparam logic [2:0][31:0] RISE_HEAP  = {32'd15000, 32'd25000, 32'd40000};
    localparam logic [2:0][31:0] RISE_ALLOC = {32'd8000, 32'd12000, 32'd20000};
    localparam logic [2:0][31:0] FALL_AVG   = {32'd115200, 32'd64000, 32'd35840};
    localparam logic [2:0][31:0] FALL_HEAP  = {32'd22000, 32'd35000, 32'd55000};
    localparam logic [2:0][31:0] FALL_ALLOC = {32'd11000, 32'd18000, 32'd30000};

    localparam longint SMOOTH_GAIN = 9830;       // 0.15 in Q0.16
    localparam longint AVG_CEIL    = 16777215;

    // Mirrored registers and state
    logic [15:0] interval_ms;
    logic        tune_on;
    logic [23:0] avg_q;
    logic [1:0]  level;
    logic [31:0] last_eval;

    lslg_pkg::lslg_rsp_t governor_results_q[$];
    lslg_pkg::lslg_rsp_t predicted;
    lslg_pkg::lslg_rsp_t oldest;

    // One smoothing step: avg += floor((x - avg) * gain / 2^16), clamped
    function automatic logic [23:0] smooth_frame(input logic [23:0] avg,
                                                 input logic [15:0] ms);
        longint diff;
        longint next;
        diff = longint'({ms, 8'h00}) - longint'(avg);
        next = longint'(avg) + ((diff * SMOOTH_GAIN) >>> 16);
        if (next < 0)
            next = 0;
        else if (next > AVG_CEIL)
            next = AVG_CEIL;
        smooth_frame = next[23:0];
    endfunction

    // Advance the mirrored governor by one item and form its result
    task automatic advance_governor(input lslg_pkg::lslg_req_t item,
                                    output lslg_pkg::lslg_rsp_t result);
        logic did;
        logic climb;
        did = 1'b0;
        climb = 1'b0;
        if (item.req_type == lslg_pkg::REQ_FRAME)
            avg_q = smooth_frame(avg_q, item.frame_ms);
        else if (!tune_on)
            level = lslg_pkg::LEVEL_MIN;
        else if (item.now_ms - last_eval >= {16'd0, interval_ms})
        begin
            did = 1'b1;
            last_eval = item.now_ms;
            if (level != lslg_pkg::LEVEL_MAX)
                climb = ({8'd0, avg_q} > RISE_AVG[level]) ||
                        (item.free_heap < RISE_HEAP[level]) ||
                        (item.max_alloc < RISE_ALLOC[level]);
            // escalation wins; recovery looks at the step below
            if (climb)
                level = level + 2'd1;
            else if (level != lslg_pkg::LEVEL_MIN &&
                     {8'd0, avg_q} < FALL_AVG[level - 2'd1] &&
                     item.free_heap > FALL_HEAP[level - 2'd1] &&
                     item.max_alloc > FALL_ALLOC[level - 2'd1])
                level = level - 2'd1;
        end
        result.load_level     = level;
        result.effects_off    = (level >= 2'd1);
        result.sweep_simple   = (level >= 2'd2);
        result.detail_reduced = (level == 2'd3);
        result.avg_frame_ms   = avg_q;
        result.evaluated      = did;
    endtask

    task automatic compare_result(input lslg_pkg::lslg_rsp_t want,
                                  input lslg_pkg::lslg_rsp_t got);
        if (got.load_level !== want.load_level)
        begin
            $error("load_level: expected %0d, got %0d", want.load_level, got.load_level);
            mismatches++;
        end
        if (got.effects_off !== want.effects_off)
        begin
            $error("effects_off: expected %0d, got %0d", want.effects_off, got.effects_off);
            mismatches++;
        end
        if (got.sweep_simple !== want.sweep_simple)
        begin
            $error("sweep_simple: expected %0d, got %0d", want.sweep_simple, got.sweep_simple);
            mismatches++;
        end
        if (got.detail_reduced !== want.detail_reduced)
        begin
            $error("detail_reduced: expected %0d, got %0d",
                   want.detail_reduced, got.detail_reduced);
            mismatches++;
        end
        if (got.avg_frame_ms !== want.avg_frame_ms)
        begin
            $error("avg_frame_ms: expected %0d, got %0d", want.avg_frame_ms, got.avg_frame_ms);
            mismatches++;
        end
        if (got.evaluated !== want.evaluated)
        begin
            $error("evaluated: expected %0d, got %0d", want.evaluated, got.evaluated);
            mismatches++;
        end
    endtask

    // Sample both channels and the write port at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_ms  = lslg_pkg::EVAL_INTERVAL_RST;
            tune_on      = lslg_pkg::AUTO_TUNE_RST;
            avg_q        = lslg_pkg::AVG_RST;
            level        = lslg_pkg::LEVEL_MIN;
            last_eval    = '0;
            governor_results_q.delete();
            mismatches   = 0;
            outstanding  = 0;
            results_seen = 0;
            evaluations  = 0;
            levels_hit   = '0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (governor_results_q.size() == 0)
                begin
                    $error("result with no item outstanding: level %0d avg %0d",
                           rsp.load_level, rsp.avg_frame_ms);
                    mismatches++;
                end
                else
                begin
                    oldest = governor_results_q.pop_front();
                    compare_result(oldest, rsp);
                    results_seen++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == lslg_pkg::CFG_EVAL_INTERVAL)
                    interval_ms = cfg_data;
                else if (cfg_index == lslg_pkg::CFG_AUTO_TUNE)
                    tune_on = cfg_data[0];
            end
            if (req_valid && req_ready)
            begin
                advance_governor(req, predicted);
                governor_results_q.push_back(predicted);
                if (predicted.evaluated)
                    evaluations++;
                levels_hit[predicted.load_level] = 1'b1;
            end
            outstanding = governor_results_q.size();
        end
    end

endmodule

// ----- verif/load_shedding_level_governor_top_test.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the load-shedding level governor: directed level
// walk, then bursts of random frame and evaluation items across settings.
// Depends on lslg_pkg, load_shedding_level_governor_top and lslg_checker.

module load_shedding_level_governor_top_test;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    lslg_pkg::lslg_req_t             req = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    lslg_pkg::lslg_rsp_t             rsp;
    logic                            cfg_we = 1'b0;
    logic [lslg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [lslg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned results_seen;
    int unsigned evaluations;
    logic [3:0]  levels_hit;

    // Stimulus shaping state
    logic        steady_flow = 1'b0;     // both sides run without gaps
    logic [15:0] interval_now = lslg_pkg::EVAL_INTERVAL_RST;
    logic [31:0] clock_ms = '0;
    int unsigned burst_left = 0;
    int unsigned frame_band = 0;
    int unsigned mem_band = 0;

    always #4 clk = ~clk;

    load_shedding_level_governor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lslg_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .rsp          (rsp),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .evaluations  (evaluations),
        .levels_hit   (levels_hit)
    );

    function automatic lslg_pkg::lslg_req_t frame_req(input logic [15:0] ms);
        lslg_pkg::lslg_req_t r;
        r.req_type  = lslg_pkg::REQ_FRAME;
        r.frame_ms  = ms;
        r.now_ms    = $urandom;
        r.free_heap = $urandom;
        r.max_alloc = $urandom;
        frame_req = r;
    endfunction

    function automatic lslg_pkg::lslg_req_t eval_req(input logic [31:0] now,
                                                     input logic [31:0] heap,
                                                     input logic [31:0] alloc);
        lslg_pkg::lslg_req_t r;
        r.req_type  = lslg_pkg::REQ_EVAL;
        r.frame_ms  = 16'($urandom);
        r.now_ms    = now;
        r.free_heap = heap;
        r.max_alloc = alloc;
        eval_req = r;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input lslg_pkg::lslg_req_t item);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 18);
        @(negedge clk);
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every result has been taken
    task automatic settle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic set_register(input logic [lslg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] val);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == lslg_pkg::CFG_EVAL_INTERVAL)
            interval_now = val;
    endtask

    // Random item: bursts with a frame-time band and a memory band,
    // time stamps mostly spaced past the interval, some noise
    task automatic gen_item(output lslg_pkg::lslg_req_t item);
        int unsigned pick;
        int unsigned spacing;
        logic [31:0] step;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(6, 24);
            frame_band = $urandom_range(0, 4);
            mem_band   = $urandom_range(0, 3);
        end
        burst_left--;
        item = frame_req(16'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 7)
        begin
            // noise: every field random
            item.req_type = 1'($urandom_range(0, 1));
            if (item.req_type == lslg_pkg::REQ_EVAL)
                clock_ms = item.now_ms;
        end
        else if (pick < 42)
        begin
            spacing = $urandom_range(0, 99);
            if (spacing < 70)
                step = {16'd0, interval_now} + $urandom_range(0, 40);
            else if (spacing < 85)
                step = $urandom_range(0, interval_now);
            else if (spacing < 95)
                step = {16'd0, interval_now} - $urandom_range(0, 1);
            else
                step = $urandom;
            clock_ms = clock_ms + step;
            item.req_type = lslg_pkg::REQ_EVAL;
            item.now_ms   = clock_ms;
            case (mem_band)
                0:
                begin
                    item.free_heap = $urandom_range(56000, 32'hFFFF_FFFF);
                    item.max_alloc = $urandom_range(31000, 32'hFFFF_FFFF);
                end
                1:
                begin
                    item.free_heap = $urandom_range(14000, 56000);
                    item.max_alloc = $urandom_range(7000, 31000);
                end
                2:
                begin
                    item.free_heap = $urandom_range(0, 42000);
                    item.max_alloc = $urandom_range(0, 21000);
                end
                default: ;   // full-range memory figures
            endcase
        end
        else
        begin
            case (frame_band)
                0:       item.frame_ms = 16'($urandom_range(0, 60));
                1:       item.frame_ms = 16'($urandom_range(60, 300));
                2:       item.frame_ms = 16'($urandom_range(300, 800));
                3:       item.frame_ms = 16'($urandom_range(800, 3000));
                default: ;   // full 16-bit range
            endcase
        end
    endtask

    task automatic run_random(input int unsigned count);
        lslg_pkg::lslg_req_t item;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            gen_item(item);
            send_item(item);
        end
        steady_flow = 1'b0;
    endtask

    // Reset, once
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Result side: random stalls, two long hold-offs that back up the block
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        taken = 0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            stall = steady_flow ? 0 : $urandom_range(0, 18);
            if (taken == 300 || taken == 600)
                stall = 160;
            if (stall != 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            taken++;
        end
    end

    // Main sequence
    initial
    begin
        wait (rst_n);

        // Level walk at reset settings: too early, escalation by the heap
        // and allocation figures, recovery one step at a time, threshold equality
        send_item(frame_req(16'd0));
        send_item(eval_req(32'd1999, '1, '1));
        send_item(eval_req(32'd2000, 32'd0, '1));
        send_item(eval_req(32'd3999, '1, '1));
        send_item(eval_req(32'd4000, '1, 32'd0));
        send_item(eval_req(32'd6000, 32'd14999, '1));
        send_item(eval_req(32'd8000, '1, '1));
        send_item(eval_req(32'd10000, 32'd35000, '1));
        send_item(eval_req(32'd12000, 32'd35001, 32'd18001));
        send_item(eval_req(32'd14000, 32'd55001, 32'd30000));
        send_item(eval_req(32'd16000, 32'd55001, 32'd30001));
        send_item(eval_req(32'd18000, 32'd40000, 32'd20000));

        // Zero interval: same time stamp and a backward one both evaluate
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'd0);
        send_item(eval_req(32'd18000, 32'd39999, '1));
        send_item(eval_req(32'd0, '1, '1));
        send_item(frame_req(16'hFFFF));
        send_item(eval_req(32'd5, '1, '1));

        // Disabled: level forced to zero, average still tracks
        set_register(lslg_pkg::CFG_AUTO_TUNE, 16'd0);
        send_item(eval_req(32'd50000, 32'd0, 32'd0));
        send_item(frame_req(16'd100));

        // Longest interval across the 32-bit wrap
        set_register(lslg_pkg::CFG_AUTO_TUNE, 16'd1);
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'hFFFF);
        send_item(eval_req(32'hFFFF_FF00, '1, '1));
        send_item(eval_req(32'h0000_FEFE, '1, '1));
        send_item(eval_req(32'h0000_FEFF, '1, '1));
        clock_ms = 32'h0000_FEFF;

        // Random phases over several settings
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'd1);
        run_random(220);
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'($urandom_range(100, 3000)));
        run_random(200);
        set_register(lslg_pkg::CFG_AUTO_TUNE, 16'd0);
        run_random(60);
        set_register(lslg_pkg::CFG_AUTO_TUNE, 16'd1);
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'hFFFF);
        run_random(120);
        set_register(lslg_pkg::CFG_EVAL_INTERVAL, 16'd0);
        run_random(130);

        settle();
        repeat (8) @(negedge clk);

        $display("Checked %0d results, %0d of them evaluations.", results_seen, evaluations);
        $display("Levels reached (bit per level): %b; intervals 0, 1, 65535 and random.",
                 levels_hit);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
